FILE: rtl/core/prt_pkg.sv
package prt_pkg;

  localparam int unsigned PhW = 17;
  localparam int unsigned RateW = 16;
  localparam int unsigned IdW = 6;
  localparam int unsigned DestW = 6;
  localparam int unsigned DrawW = 16;
  localparam int unsigned StW = 3;

  localparam logic [PhW-1:0] PH_ONE = 17'h10000;
  localparam logic [RateW-1:0] RATE_RESET = 16'd6554;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_REINFORCE = 2'd1;
  localparam logic [1:0] KIND_SELECT = 2'd2;
  localparam logic [1:0] KIND_NOP = 2'd3;

  localparam logic [StW-1:0] ST_OK = 3'd0;
  localparam logic [StW-1:0] ST_RETRY = 3'd1;
  localparam logic [StW-1:0] ST_NOROUTE = 3'd2;
  localparam logic [StW-1:0] ST_FULL = 3'd3;
  localparam logic [StW-1:0] ST_LOOP = 3'd4;

  typedef enum logic [2:0] {
    RES_OK,
    RES_FULL,
    RES_LOOP,
    RES_RETRY,
    RES_NOROUTE,
    RES_HIT
  } res_e;

  typedef struct packed {
    logic load;
    logic cnt_load;
    logic slot_clr;
    logic slot_inc;
    logic acc_clr;
    logic acc_add;
    logic par_cap;
    logic mul_go;
    logic ph_wr;
    logic add_wr;
    logic res_set;
    res_e res;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic oor;
    logic full;
    logic slot_end;
    logic is_parent;
    logic in_range;
    logic loop;
    logic retry;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/core/prt_ctrl.sv
module prt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  prt_pkg::sts_t sts_i,
  output prt_pkg::cmd_t cmd_o
);
  import prt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT1,
    S_CNT2,
    S_DISP,
    S_R_CHK,
    S_R_MUL,
    S_R_WR,
    S_S1_CHK,
    S_S1_USE,
    S_S1_EVAL,
    S_S2_CHK,
    S_S2_USE,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.res = RES_OK;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_CNT1;
        end
      end
      S_CNT1: state_d = S_CNT2;
      S_CNT2: begin
        cmd_o.cnt_load = 1'b1;
        cmd_o.slot_clr = 1'b1;
        cmd_o.acc_clr = 1'b1;
        state_d = S_DISP;
      end
      S_DISP: begin
        unique case (sts_i.kind)
          KIND_ADD: begin
            cmd_o.res_set = 1'b1;
            if (sts_i.oor || sts_i.full) begin
              cmd_o.res = RES_FULL;
            end else begin
              cmd_o.add_wr = 1'b1;
              cmd_o.res = RES_OK;
            end
            state_d = S_FIN;
          end
          KIND_REINFORCE: state_d = S_R_CHK;
          KIND_SELECT: state_d = S_S1_CHK;
          default: begin
            cmd_o.res_set = 1'b1;
            cmd_o.res = RES_OK;
            state_d = S_FIN;
          end
        endcase
      end
      S_R_CHK: begin
        if (sts_i.slot_end) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res = RES_OK;
          state_d = S_FIN;
        end else begin
          state_d = S_R_MUL;
        end
      end
      S_R_MUL: begin
        cmd_o.mul_go = 1'b1;
        state_d = S_R_WR;
      end
      S_R_WR: begin
        cmd_o.ph_wr = 1'b1;
        cmd_o.slot_inc = 1'b1;
        state_d = S_R_CHK;
      end
      S_S1_CHK: begin
        state_d = sts_i.slot_end ? S_S1_EVAL : S_S1_USE;
      end
      S_S1_USE: begin
        if (sts_i.is_parent) begin
          cmd_o.par_cap = 1'b1;
          state_d = S_S1_EVAL;
        end else begin
          cmd_o.acc_add = 1'b1;
          cmd_o.slot_inc = 1'b1;
          state_d = S_S1_CHK;
        end
      end
      S_S1_EVAL: begin
        if (sts_i.loop) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res = RES_LOOP;
          state_d = S_FIN;
        end else if (sts_i.retry) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res = RES_RETRY;
          state_d = S_FIN;
        end else begin
          cmd_o.acc_clr = 1'b1;
          cmd_o.slot_clr = 1'b1;
          state_d = S_S2_CHK;
        end
      end
      S_S2_CHK: begin
        if (sts_i.slot_end) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res = RES_NOROUTE;
          state_d = S_FIN;
        end else begin
          state_d = S_S2_USE;
        end
      end
      S_S2_USE: begin
        if (sts_i.in_range) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res = RES_HIT;
          state_d = S_FIN;
        end else begin
          cmd_o.acc_add = 1'b1;
          cmd_o.slot_inc = 1'b1;
          state_d = S_S2_CHK;
        end
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/prt_dp.sv
module prt_dp #(
  parameter int unsigned DEST_COUNT = 64,
  parameter int unsigned NEIGHBOR_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [prt_pkg::RateW-1:0]     cfg_wdata_i,
  input  logic [1:0]                    kind_i,
  input  logic [prt_pkg::DestW-1:0]     destination_i,
  input  logic [prt_pkg::IdW-1:0]       neighbor_i,
  input  logic [prt_pkg::PhW-1:0]       pheromone_i,
  input  logic [prt_pkg::DrawW-1:0]     random_draw_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [prt_pkg::IdW-1:0]       next_hop_o,
  output logic [prt_pkg::StW-1:0]       status_o,
  input  prt_pkg::cmd_t                 cmd_i,
  output prt_pkg::sts_t                 sts_o
);
  import prt_pkg::*;

  localparam int unsigned Rows = (DEST_COUNT < 64) ? DEST_COUNT : 64;
  localparam int unsigned RowW = $clog2(Rows);
  localparam int unsigned Depth = Rows * NEIGHBOR_SLOTS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(NEIGHBOR_SLOTS + 1);
  localparam int unsigned SumW = PhW + $clog2(NEIGHBOR_SLOTS) + 1;

  logic [RateW-1:0] rate_q;
  logic [1:0]       kind_q;
  logic [DestW-1:0] dest_q;
  logic [IdW-1:0]   nb_q;
  logic [PhW-1:0]   ph_q;
  logic [DrawW-1:0] draw_q;

  logic [IdW-1:0] id_mem [Depth];
  logic [PhW-1:0] ph_mem [Depth];
  logic [CntW-1:0] cnt_mem [Rows];
  logic [Rows-1:0] cnt_vld_q;

  logic [CntW-1:0] cnt_rd_q;
  logic            vld_rd_q;
  logic [CntW-1:0] n_q;
  logic [CntW-1:0] slot_q;
  logic [IdW-1:0]  ent_id_q;
  logic [PhW-1:0]  ent_ph_q;
  logic [33:0]     prod_q;
  logic [SumW-1:0] acc_q;
  logic [SumW-1:0] hi_q;
  logic            found_q;
  logic [IdW-1:0]  pend_hop_q;
  logic [StW-1:0]  pend_st_q;
  logic            out_valid_q;
  logic [IdW-1:0]  next_hop_q;
  logic [StW-1:0]  status_q;

  logic [RowW-1:0]  row;
  logic             oor;
  logic [AddrW-1:0] addr;
  logic [PhW-1:0]   mul_a, mul_b;
  logic [PhW:0]     new_ph_w;
  logic [PhW-1:0]   new_ph;
  logic [PhW-1:0]   add_ph;
  logic [SumW-1:0]  acc_next;
  logic [SumW-1:0]  hi_eff;
  logic [SumW-1:0]  draw_w;
  logic [SumW-1:0]  one_w;

  assign row = dest_q[RowW-1:0];
  assign oor = (32'(dest_q) >= DEST_COUNT);
  assign addr = AddrW'(row) * AddrW'(NEIGHBOR_SLOTS)
              + AddrW'(cmd_i.add_wr ? n_q : slot_q);

  assign mul_a = (ent_id_q == nb_q) ? {1'b0, rate_q} : (PH_ONE - {1'b0, rate_q});
  assign mul_b = (ent_id_q == nb_q) ? (PH_ONE - ent_ph_q) : ent_ph_q;
  assign new_ph_w = (ent_id_q == nb_q) ? ({1'b0, ent_ph_q} + {1'b0, prod_q[32:16]})
                                       : {1'b0, prod_q[32:16]};
  assign new_ph = new_ph_w[PhW-1:0];
  assign add_ph = (ph_q > PH_ONE) ? PH_ONE : ph_q;

  assign acc_next = acc_q + SumW'(ent_ph_q);
  assign one_w = SumW'(PH_ONE);
  assign draw_w = SumW'(draw_q);
  assign hi_eff = (!found_q || hi_q == '0) ? one_w : hi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) begin
      id_mem[addr] <= nb_q;
    end
    if (cmd_i.add_wr) begin
      ph_mem[addr] <= add_ph;
    end else if (cmd_i.ph_wr) begin
      ph_mem[addr] <= new_ph;
    end
    ent_id_q <= id_mem[addr];
    ent_ph_q <= ph_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) begin
      cnt_mem[row] <= n_q + CntW'(1);
    end
    cnt_rd_q <= cnt_mem[row];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      dest_q <= destination_i;
      nb_q   <= neighbor_i;
      ph_q   <= pheromone_i;
      draw_q <= random_draw_i;
    end
    if (cmd_i.mul_go) begin
      prod_q <= 34'(mul_a) * 34'(mul_b);
    end
    if (cmd_i.par_cap) begin
      hi_q <= acc_next;
    end
    if (cmd_i.res_set) begin
      case (cmd_i.res)
        RES_OK:      pend_st_q <= ST_OK;
        RES_FULL:    pend_st_q <= ST_FULL;
        RES_LOOP:    pend_st_q <= ST_LOOP;
        RES_RETRY:   pend_st_q <= ST_RETRY;
        RES_NOROUTE: pend_st_q <= ST_NOROUTE;
        RES_HIT:     pend_st_q <= ST_OK;
        default:     pend_st_q <= ST_OK;
      endcase
      case (cmd_i.res)
        RES_LOOP: pend_hop_q <= nb_q;
        RES_HIT:  pend_hop_q <= ent_id_q;
        default:  pend_hop_q <= '0;
      endcase
    end
    if (cmd_i.out_load) begin
      next_hop_q <= pend_hop_q;
      status_q   <= pend_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RATE_RESET;
      cnt_vld_q   <= '0;
      vld_rd_q    <= 1'b0;
      n_q         <= '0;
      slot_q      <= '0;
      acc_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (cmd_i.add_wr) begin
        cnt_vld_q[row] <= 1'b1;
      end
      vld_rd_q <= cnt_vld_q[row];
      if (cmd_i.cnt_load) begin
        n_q <= (oor || !vld_rd_q) ? '0 : cnt_rd_q;
      end
      if (cmd_i.slot_clr) begin
        slot_q <= '0;
      end else if (cmd_i.slot_inc) begin
        slot_q <= slot_q + CntW'(1);
      end
      if (cmd_i.acc_clr) begin
        acc_q <= '0;
      end else if (cmd_i.acc_add) begin
        acc_q <= acc_next;
      end
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.par_cap) begin
        found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.kind      = kind_q;
  assign sts_o.oor       = oor;
  assign sts_o.full      = (n_q == CntW'(NEIGHBOR_SLOTS));
  assign sts_o.slot_end  = (slot_q == n_q);
  assign sts_o.is_parent = (ent_id_q == nb_q);
  assign sts_o.in_range  = (draw_w >= acc_q) && (draw_w < acc_next);
  assign sts_o.loop      = (acc_q == '0) && (hi_eff == one_w);
  assign sts_o.retry     = (draw_w >= acc_q) && (draw_w < hi_eff);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign next_hop_o  = next_hop_q;
  assign status_o    = status_q;

  a_add_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |-> (!oor && n_q != CntW'(NEIGHBOR_SLOTS)))
    else $error("Add wrote into a full or absent row.");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= n_q)
    else $error("Slot index ran past the row length.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (status_q <= ST_LOOP))
    else $error("Undefined status code delivered.");

  a_hop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_RETRY || status_q == ST_NOROUTE
                     || status_q == ST_FULL)) |-> (next_hop_q == '0))
    else $error("Nonzero next hop with a failing status.");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("Result overwrote a request still waiting.");

endmodule

FILE: rtl/core/pheromone_route_table.sv
// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid_i / in_stall_o | kind, destination, neighbor, pheromone, draw
// output  | out       | out_valid_o/out_stall_i | next_hop, status
// config  | in        | cfg_we_i                | cfg_wdata_i (reinforce rate)
// After accept the row count is read; an add then writes the entry or reports the row full,
// a reinforce updates each entry of its row in turn (check, multiply, write), and a select
// scans the row in two passes; the single-port entry memory keeps every step to one entry.
// The input stalls until the result is loaded and can take the next request in the cycle after.
// Reset clears row counts through per-row valid bits and sets the rate to 6554.
// A new request is taken while a result waits on a stalled output, and waits to deliver its own.
module pheromone_route_table #(
  parameter int unsigned DEST_COUNT = 64,
  parameter int unsigned NEIGHBOR_SLOTS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [prt_pkg::RateW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                kind_i,
  input  logic [prt_pkg::DestW-1:0] destination_i,
  input  logic [prt_pkg::IdW-1:0]   neighbor_i,
  input  logic [prt_pkg::PhW-1:0]   pheromone_i,
  input  logic [prt_pkg::DrawW-1:0] random_draw_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [prt_pkg::IdW-1:0]   next_hop_o,
  output logic [prt_pkg::StW-1:0]   status_o
);
  import prt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  prt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prt_dp #(
    .DEST_COUNT     (DEST_COUNT),
    .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (kind_i),
    .destination_i (destination_i),
    .neighbor_i    (neighbor_i),
    .pheromone_i   (pheromone_i),
    .random_draw_i (random_draw_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .next_hop_o    (next_hop_o),
    .status_o      (status_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
